// ===== rtl/keyframe_curve_interpolator_assert.svh =====
// Assertion macros for the curve interpolator.
`ifndef KEYFRAME_CURVE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KCI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KCI_ASSERT_NR(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCI_ASSERT(label, prop, msg)
`define KCI_ASSERT_NR(label, prop, msg)
`endif
`endif

// ===== rtl/kci_pkg.sv =====
package kci_pkg;
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_LINEAR = 2'd1,
		CMD_HERMITE = 2'd2,
		CMD_BEZIER = 2'd3
	} cmd_t;

	localparam int ValueWidth = 32;
	localparam int InDataWidth = 224;
	localparam int OutDataWidth = 32;
	localparam int OutUserWidth = 2;
endpackage

// ===== rtl/kci_divider.sv =====
module kci_divider #(
	parameter int FRACTION_BITS = 16,
	parameter int TIME_WIDTH = 31,
	parameter int SIDE_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   in_valid,
	input  logic [TIME_WIDTH-1:0]  query_time,
	input  logic [TIME_WIDTH-1:0]  start_key_time,
	input  logic [TIME_WIDTH-1:0]  end_key_time,
	input  logic [SIDE_WIDTH-1:0]  side_in,
	output logic                   out_valid,
	output logic [FRACTION_BITS:0] factor,
	output logic                   clamped,
	output logic [SIDE_WIDTH-1:0]  side_out
);
	localparam int Steps = FRACTION_BITS + 1;
	localparam int RemWidth = TIME_WIDTH + 1;

	logic [TIME_WIDTH:0] an_c, ad_c;
	logic                neg_n_c, neg_d_c, clamp_c, one_c;
	logic signed [TIME_WIDTH:0] n_c, d_c;

	always_comb begin
		n_c = $signed({1'b0, query_time}) - $signed({1'b0, start_key_time});
		d_c = $signed({1'b0, end_key_time}) - $signed({1'b0, start_key_time});
		neg_n_c = n_c[TIME_WIDTH];
		neg_d_c = d_c[TIME_WIDTH];
		an_c = neg_n_c ? -n_c : n_c;
		ad_c = neg_d_c ? -d_c : d_c;
		clamp_c = 1'b0;
		one_c = 1'b0;
		if (d_c == '0) begin
			clamp_c = 1'b1;
		end else if (n_c != '0 && neg_n_c != neg_d_c) begin
			clamp_c = 1'b1;
		end else if (an_c > ad_c) begin
			clamp_c = 1'b1;
			one_c = 1'b1;
		end
	end

	logic                  vld_s [Steps+1];
	logic [RemWidth:0]     rem_s [Steps+1];
	logic [TIME_WIDTH:0]   den_s [Steps+1];
	logic [FRACTION_BITS:0] quo_s [Steps+1];
	logic                  clp_s [Steps+1];
	logic                  one_s [Steps+1];
	logic [SIDE_WIDTH-1:0] side_s [Steps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0] <= {1'b0, (clamp_c ? '0 : an_c)};
			den_s[0] <= clamp_c ? {{TIME_WIDTH{1'b0}}, 1'b1} : ad_c;
			quo_s[0] <= '0;
			clp_s[0] <= clamp_c;
			one_s[0] <= one_c;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		logic [RemWidth:0] sh_c, diff_c;
		logic              ge_c;
		always_comb begin
			if (i == 0) begin
				sh_c = rem_s[i];
			end else begin
				sh_c = {rem_s[i][RemWidth-1:0], 1'b0};
			end
			ge_c = sh_c >= {1'b0, den_s[i]};
			diff_c = sh_c - {1'b0, den_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (advance) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[i+1] <= ge_c ? diff_c : sh_c;
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][FRACTION_BITS-1:0], ge_c};
				clp_s[i+1] <= clp_s[i];
				one_s[i+1] <= one_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[Steps];
	assign factor = one_s[Steps] ? {1'b1, {FRACTION_BITS{1'b0}}} : quo_s[Steps];
	assign clamped = clp_s[Steps];
	assign side_out = side_s[Steps];
endmodule

// ===== rtl/kci_weights.sv =====
module kci_weights #(
	parameter int FRACTION_BITS = 16,
	parameter int SIDE_WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    in_valid,
	input  logic [FRACTION_BITS:0]  factor,
	input  logic [1:0]              mode,
	input  logic [SIDE_WIDTH-1:0]   side_in,
	output logic                    out_valid,
	output logic signed [FRACTION_BITS+3:0] w0,
	output logic signed [FRACTION_BITS+3:0] w1,
	output logic signed [FRACTION_BITS+3:0] w2,
	output logic signed [FRACTION_BITS+3:0] w3,
	output logic [SIDE_WIDTH-1:0]   side_out
);
	import kci_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam int PW = 2 * F + 2;
	localparam int WW = F + 4;
	localparam logic [PW-1:0] Half = PW'(1) << (F - 1);
	localparam logic [F:0] One = (F+1)'(1) << F;

	function automatic logic [F:0] rnd(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p + Half) >> F;
		return r[F:0];
	endfunction

	logic          v1_s, v2_s, v3_s;
	logic [F:0]    t_s1, u_s1, t2_s1, u2_s1;
	logic [F:0]    t_s2, u_s2, t2_s2, t3_s2, u3_s2, m1_s2, m2_s2;
	logic [1:0]    md_s1, md_s2;
	logic [SIDE_WIDTH-1:0] sd_s1, sd_s2, sd_s3;
	logic signed [WW-1:0] w0_s3, w1_s3, w2_s3, w3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
		end else if (advance) begin
			v1_s <= in_valid;
			v2_s <= v1_s;
			v3_s <= v2_s;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s1 <= factor;
			u_s1 <= One - factor;
			t2_s1 <= rnd(PW'(factor) * PW'(factor));
			u2_s1 <= rnd(PW'(One - factor) * PW'(One - factor));
			md_s1 <= mode;
			sd_s1 <= side_in;

			t_s2 <= t_s1;
			u_s2 <= u_s1;
			t2_s2 <= t2_s1;
			t3_s2 <= rnd(PW'(t2_s1) * PW'(t_s1));
			u3_s2 <= rnd(PW'(u2_s1) * PW'(u_s1));
			m1_s2 <= rnd(PW'(t_s1) * PW'(u2_s1));
			m2_s2 <= rnd(PW'(t2_s1) * PW'(u_s1));
			md_s2 <= md_s1;
			sd_s2 <= sd_s1;
			sd_s3 <= sd_s2;
		end
	end

	logic signed [WW-1:0] t_c, t2_c, t3_c, u3_c, m1_c, m2_c, one_c;
	logic signed [WW-1:0] a0_c, a1_c, a2_c, a3_c;

	always_comb begin
		t_c = WW'(t_s2);
		t2_c = WW'(t2_s2);
		t3_c = WW'(t3_s2);
		u3_c = WW'(u3_s2);
		m1_c = WW'(m1_s2);
		m2_c = WW'(m2_s2);
		one_c = WW'(One);
		case (cmd_t'(md_s2))
			CMD_LINEAR: begin
				a0_c = WW'(u_s2);
				a1_c = '0;
				a2_c = '0;
				a3_c = t_c;
			end
			CMD_HERMITE: begin
				a0_c = WW'(2 * t3_c - 3 * t2_c + one_c);
				a1_c = WW'(t3_c - 2 * t2_c + t_c);
				a2_c = t3_c - t2_c;
				a3_c = WW'(3 * t2_c - 2 * t3_c);
			end
			CMD_BEZIER: begin
				a0_c = u3_c;
				a1_c = WW'(3 * m1_c);
				a2_c = WW'(3 * m2_c);
				a3_c = t3_c;
			end
			default: begin
				a0_c = '0;
				a1_c = '0;
				a2_c = '0;
				a3_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			w0_s3 <= a0_c;
			w1_s3 <= a1_c;
			w2_s3 <= a2_c;
			w3_s3 <= a3_c;
		end
	end

	assign out_valid = v3_s;
	assign w0 = w0_s3;
	assign w1 = w1_s3;
	assign w2 = w2_s3;
	assign w3 = w3_s3;
	assign side_out = sd_s3;
endmodule

// ===== rtl/kci_blend.sv =====
module kci_blend #(
	parameter int FRACTION_BITS = 16,
	parameter int SIDE_WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    in_valid,
	input  logic signed [FRACTION_BITS+3:0] w0,
	input  logic signed [FRACTION_BITS+3:0] w1,
	input  logic signed [FRACTION_BITS+3:0] w2,
	input  logic signed [FRACTION_BITS+3:0] w3,
	input  logic signed [31:0]      p0,
	input  logic signed [31:0]      t0,
	input  logic signed [31:0]      t1,
	input  logic signed [31:0]      p1,
	input  logic [SIDE_WIDTH-1:0]   side_in,
	output logic                    out_valid,
	output logic signed [31:0]      value,
	output logic [SIDE_WIDTH-1:0]   side_out
);
	localparam int F = FRACTION_BITS;
	localparam int PW = F + 36;
	localparam int AW = PW + 2;
	localparam logic signed [AW-1:0] Half = AW'(1) << (F - 1);
	localparam logic signed [AW-1:0] MaxV = AW'(32'sh7fffffff);
	localparam logic signed [AW-1:0] MinV = -(AW'(64'sh80000000));

	logic v1_s, v2_s, v3_s;
	logic signed [PW-1:0] pr0_s1, pr1_s1, pr2_s1, pr3_s1;
	logic signed [AW-1:0] sa_s2, sb_s2, acc_c, r_c;
	logic signed [31:0] val_s3;
	logic [SIDE_WIDTH-1:0] sd_s1, sd_s2, sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
		end else if (advance) begin
			v1_s <= in_valid;
			v2_s <= v1_s;
			v3_s <= v2_s;
		end
	end

	always_comb begin
		acc_c = sa_s2 + sb_s2 + Half;
		r_c = acc_c >>> F;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pr0_s1 <= PW'(w0) * PW'(p0);
			pr1_s1 <= PW'(w1) * PW'(t0);
			pr2_s1 <= PW'(w2) * PW'(t1);
			pr3_s1 <= PW'(w3) * PW'(p1);
			sd_s1 <= side_in;
			sa_s2 <= AW'(pr0_s1) + AW'(pr1_s1);
			sb_s2 <= AW'(pr2_s1) + AW'(pr3_s1);
			sd_s2 <= sd_s1;
			if (r_c > MaxV) begin
				val_s3 <= 32'sh7fffffff;
			end else if (r_c < MinV) begin
				val_s3 <= 32'sh80000000;
			end else begin
				val_s3 <= r_c[31:0];
			end
			sd_s3 <= sd_s2;
		end
	end

	assign out_valid = v3_s;
	assign value = val_s3;
	assign side_out = sd_s3;
endmodule

// ===== rtl/keyframe_curve_interpolator.sv =====
// Keyframe curve interpolator: samples one animation curve component per item.
// The input channel (s_axis) carries an item with the mode, query time, both key
// times, start value, start out tangent, end in tangent and end value. The output
// channel (m_axis) returns the Q16.16 curve value, saturated, with tuser flags for
// a forced w of one (hold mode) and a clamped factor.
// The block is a single pipeline: a restoring divider (FRACTION_BITS + 2 stages:
// an input stage, then one quotient bit per stage), three stages for the powers
// and weights, and three stages for the products, the sum and the saturation.
// One item is accepted every cycle while the receiver does not stall the output.
// The pipeline advances whenever its last stage is empty or being taken, so a
// stalled receiver holds every stage in place; no item is dropped or repeated.
// Reset clears all valid bits, so the block comes out of reset empty and ready.
module keyframe_curve_interpolator #(
	parameter int FRACTION_BITS = 16,
	parameter int TIME_WIDTH = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// query_time, start_key_time, end_key_time, start_value, start_out_tangent,
	// end_in_tangent, end_value from bit 0 up, zero filled to 224 bits
	input  logic [kci_pkg::InDataWidth-1:0]     s_axis_tdata,
	// command
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// curve_value
	output logic [kci_pkg::OutDataWidth-1:0]    m_axis_tdata,
	// w_forced_one, factor_clamped from bit 0 up
	output logic [kci_pkg::OutUserWidth-1:0]    m_axis_tuser
);
	import kci_pkg::*;

	`include "keyframe_curve_interpolator_assert.svh"

	localparam int SW = 2 + 4 * ValueWidth;
	localparam int SW2 = SW + 1;
	localparam int WW = FRACTION_BITS + 4;

	logic advance;
	logic [TIME_WIDTH-1:0] q_c, s_c, e_c;
	logic [SW-1:0] side_in;
	logic d_vld, d_clp, w_vld, b_vld;
	logic [FRACTION_BITS:0] d_fac;
	logic [SW-1:0] d_side;
	logic [SW2-1:0] w_side, b_side;
	logic signed [WW-1:0] w0, w1, w2, w3;
	logic signed [31:0] b_val;

	assign advance = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = advance;

	assign q_c = TIME_WIDTH'(s_axis_tdata[30:0]);
	assign s_c = TIME_WIDTH'(s_axis_tdata[61:31]);
	assign e_c = TIME_WIDTH'(s_axis_tdata[92:62]);
	assign side_in = {s_axis_tdata[220:93], s_axis_tuser};

	kci_divider #(
		.FRACTION_BITS(FRACTION_BITS),
		.TIME_WIDTH(TIME_WIDTH),
		.SIDE_WIDTH(SW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.in_valid(s_axis_tvalid),
		.query_time(q_c),
		.start_key_time(s_c),
		.end_key_time(e_c),
		.side_in(side_in),
		.out_valid(d_vld),
		.factor(d_fac),
		.clamped(d_clp),
		.side_out(d_side)
	);

	kci_weights #(
		.FRACTION_BITS(FRACTION_BITS),
		.SIDE_WIDTH(SW2)
	) u_wgt (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.in_valid(d_vld),
		.factor(d_fac),
		.mode(d_side[1:0]),
		.side_in({d_clp, d_side}),
		.out_valid(w_vld),
		.w0(w0),
		.w1(w1),
		.w2(w2),
		.w3(w3),
		.side_out(w_side)
	);

	kci_blend #(
		.FRACTION_BITS(FRACTION_BITS),
		.SIDE_WIDTH(SW2)
	) u_bld (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.in_valid(w_vld),
		.w0(w0),
		.w1(w1),
		.w2(w2),
		.w3(w3),
		.p0(w_side[33:2]),
		.t0(w_side[65:34]),
		.t1(w_side[97:66]),
		.p1(w_side[129:98]),
		.side_in(w_side),
		.out_valid(b_vld),
		.value(b_val),
		.side_out(b_side)
	);

	logic hold_c;
	assign hold_c = cmd_t'(b_side[1:0]) == CMD_HOLD;
	assign m_axis_tvalid = b_vld;
	assign m_axis_tdata = hold_c ? b_side[33:2] : b_val;
	assign m_axis_tuser = {b_side[SW], hold_c};

	`KCI_ASSERT(a_ready_follows_out, (s_axis_tready == (!m_axis_tvalid || m_axis_tready)), "ready mismatch")
	`KCI_ASSERT(a_stall_holds, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
	`KCI_ASSERT_NR(a_reset_empty, (!arst_n |=> !m_axis_tvalid), "valid during reset")
endmodule
